>>> sv/b64d_pkg.sv
// shared types, constants and the character classifier of the base64url decoder
// no dependencies; every other file uses this package by scoped names
package b64d_pkg;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_CHAR = 2'd1,
      ST_BAD_LEN  = 2'd2
   } status_type;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_DASH    = 8'h2d;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_PAD     = 8'h3d;

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] SX_DASH    = 6'd62;
   localparam logic [5:0] SX_UNDER   = 6'd63;

   localparam logic [1:0] LAST_SLOT  = 2'd3;

   typedef struct packed {
      logic       ok;
      logic       pad;
      logic [5:0] sextet;
   } char_class_type;

   // one decoded group, results already packed to the front of bytes
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;     // results in this job minus one
      logic            is_status;
      logic            last;
      status_type      status;
   } job_type;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type c;
      logic [7:0]     t;
      c.ok     = 1'b1;
      c.pad    = 1'b0;
      c.sextet = '0;
      t        = '0;
      if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         t = ch - CH_UPPER_A;
      end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         t = ch - CH_LOWER_A + LOWER_BASE;
      end else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         t = ch - CH_DIGIT_0 + DIGIT_BASE;
      end else if (ch == CH_DASH) begin
         t = {2'b00, SX_DASH};
      end else if (ch == CH_UNDER) begin
         t = {2'b00, SX_UNDER};
      end else if (ch == CH_PAD) begin
         c.pad = 1'b1;
      end else begin
         c.ok = 1'b0;
      end
      c.sextet = t[5:0];
      return c;
   endfunction

endpackage

>>> sv/b64d_front.sv
// front part: takes characters, collects groups of four, builds output jobs
// depends on b64d_pkg
module b64d_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [7:0]       req_char_in,
   input  logic             req_end_of_string,
   input  logic             job_full,
   output logic             job_push,
   output b64d_pkg::job_type job_out
);

   logic [2:0][5:0] sextet_ff, sextet_in;
   logic [2:0]      pad_ff, pad_in;
   logic [1:0]      count_ff, count_in;
   logic            sticky_ff, sticky_in;

   b64d_pkg::char_class_type cls;
   logic       accept;
   logic       complete;
   logic       err_now;
   logic       emit1, emit2;
   logic [7:0] b0, b1, b2;
   b64d_pkg::status_type stat;

   assign full     = job_full;
   assign accept   = push && !job_full;
   assign cls      = b64d_pkg::classify(req_char_in);
   assign complete = (count_ff == b64d_pkg::LAST_SLOT);
   assign err_now  = sticky_ff || !cls.ok;

   assign b0    = {sextet_ff[0], sextet_ff[1][5:4]};
   assign b1    = {sextet_ff[1][3:0], sextet_ff[2][5:2]};
   assign b2    = {sextet_ff[2][1:0], cls.sextet};
   assign emit1 = !pad_ff[1] && !pad_ff[2];
   assign emit2 = !pad_ff[2] && !cls.pad;

   always_comb begin
      if (!complete) begin
         stat = b64d_pkg::ST_BAD_LEN;
      end else if (err_now) begin
         stat = b64d_pkg::ST_BAD_CHAR;
      end else begin
         stat = b64d_pkg::ST_OK;
      end
   end

   always_comb begin
      job_out = '0;
      if (req_end_of_string && stat != b64d_pkg::ST_OK) begin
         job_out.is_status = 1'b1;
         job_out.last      = 1'b1;
         job_out.status    = stat;
      end else begin
         job_out.bytes[0] = b0;
         job_out.bytes[1] = emit1 ? b1 : b2;
         job_out.bytes[2] = b2;
         job_out.count    = {1'b0, emit1} + {1'b0, emit2};
         job_out.last     = req_end_of_string;
         job_out.status   = b64d_pkg::ST_OK;
      end
   end

   // end of string always yields a job; mid-string only a clean full group does
   assign job_push = accept && (req_end_of_string || (complete && !err_now));

   always_comb begin
      sextet_in = sextet_ff;
      pad_in    = pad_ff;
      count_in  = count_ff;
      sticky_in = sticky_ff;
      if (accept) begin
         if (!complete) begin
            sextet_in[count_ff] = cls.sextet;
            pad_in[count_ff]    = cls.pad;
         end
         count_in  = req_end_of_string ? 2'd0 : count_ff + 2'd1;
         sticky_in = req_end_of_string ? 1'b0 : err_now;
      end
   end

   always_ff @(posedge clock) begin
      sextet_ff <= sextet_in;
      pad_ff    <= pad_in;
      if (reset) begin
         count_ff  <= '0;
         sticky_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

>>> sv/b64d_queue.sv
// two-entry job queue between the front and back parts
// depends on b64d_pkg
module b64d_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_push,
   input  b64d_pkg::job_type job_in,
   output logic             job_full,
   input  logic             job_pop,
   output b64d_pkg::job_type job_out,
   output logic             job_empty
);

   b64d_pkg::job_type entry_ff [2];
   b64d_pkg::job_type entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] used_ff, used_in;
   logic       do_push, do_pop;

   assign job_full  = (used_ff == 2'd2);
   assign job_empty = (used_ff == 2'd0);
   assign job_out   = entry_ff[rd_ptr_ff];
   assign do_push   = job_push && !job_full;
   assign do_pop    = job_pop && !job_empty;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = job_in;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      used_in = used_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

>>> sv/b64d_back.sv
// back part: walks each job one result at a time into the output register
// depends on b64d_pkg
module b64d_back (
   input  logic             clock,
   input  logic             reset,
   input  b64d_pkg::job_type job_in,
   input  logic             job_empty,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);

   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   logic [1:0] status_ff, status_in;
   logic       load;
   logic       final_slot;

   assign load       = !job_empty && (!valid_ff || pop);
   assign final_slot = (slot_ff == job_in.count);
   assign job_pop    = load && final_slot;

   always_comb begin
      slot_in   = slot_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (load) begin
         valid_in  = 1'b1;
         bvalid_in = !job_in.is_status;
         last_in   = job_in.last && final_slot;
         status_in = final_slot ? job_in.status : b64d_pkg::ST_OK;
         case (slot_ff)
            2'd0:    byte_in = job_in.bytes[0];
            2'd1:    byte_in = job_in.bytes[1];
            2'd2:    byte_in = job_in.bytes[2];
            default: byte_in = '0;
         endcase
         slot_in = final_slot ? 2'd0 : slot_ff + 2'd1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   assign empty          = !valid_ff;
   assign rsp_byte_out   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;

endmodule

>>> sv/base64url_stream_decoder_core.sv
// channel      | handshake        | payload
// -------------+------------------+---------------------------------------------------
// request      | push / full      | req_char_in[7:0], req_end_of_string
// response     | pop / empty      | rsp_byte_out[7:0], rsp_byte_valid, rsp_last,
//              |                  | rsp_status[1:0]
//
// one character is taken per cycle while full is low; a full group yields up to three
// bytes, one per cycle from the back part while its output register is free or popped.
// a group's last character passes a queue entry before reaching the response register.
// the two-entry job queue lets characters keep arriving while the back part drains;
// full rises only when both entries wait. reset clears group count, error and queue.
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
module base64url_stream_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_string,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic [1:0] rsp_status
);

   b64d_pkg::job_type front_job;
   b64d_pkg::job_type head_job;
   logic job_push, job_full, job_pop, job_empty;

   b64d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .job_full          (job_full),
      .job_push          (job_push),
      .job_out           (front_job)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .job_push  (job_push),
      .job_in    (front_job),
      .job_full  (job_full),
      .job_pop   (job_pop),
      .job_out   (head_job),
      .job_empty (job_empty)
   );

   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_in         (head_job),
      .job_empty      (job_empty),
      .job_pop        (job_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTH
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status != b64d_pkg::ST_OK |-> rsp_last)
      else $error("nonzero status away from the final result");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_byte_valid |-> rsp_last && rsp_status != b64d_pkg::ST_OK)
      else $error("status-only result without a fault on the final result");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(job_full && job_empty))
      else $error("job queue both full and empty");

   a_no_pop_empty_queue: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("back part took a job from an empty queue");
`endif

endmodule
